@@ design/mcd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcd_pkg: shared types and constants of the min/max column decimator
// request and result layouts, register map, state and action codes
// ----------------------------------------------------------------------------
`default_nettype none

package mcd_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;

  localparam int SAMPLE_W = 24;
  localparam int CV_W     = 11;
  localparam int SPS_W    = 24;
  localparam int SS_W     = 11;
  localparam int IDX_W    = 32;
  localparam int Q_W      = IDX_W + CV_W;
  localparam int BEGIN_W  = 24;
  localparam int COL_W    = 10;
  localparam int CNT_W    = 11;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [CV_W-1:0]  CV_RST  = 11'd1024;
  localparam logic [SPS_W-1:0] SPS_RST = 24'd7500;
  localparam logic [SS_W-1:0]  SS_RST  = 11'd1;

  localparam logic [1:0] REG_COLS  = 2'd0;
  localparam logic [1:0] REG_SPS   = 2'd1;
  localparam logic [1:0] REG_SHIFT = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_SHIFT  = 2'd1,
    OP_READ   = 2'd2
  } mcd_op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } mcd_status_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_APPEND,
    ACT_UPDATE,
    ACT_READ
  } mcd_act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_COL,
    ST_RESP,
    ST_SHIFT
  } mcd_state_t;

  typedef struct packed {
    logic [OP_W-1:0]            op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [BEGIN_W-1:0]         begin_column;
    logic [COL_W-1:0]           read_column;
  } mcd_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]          status;
    logic [COL_W-1:0]           column;
    logic signed [SAMPLE_W-1:0] low_value;
    logic signed [SAMPLE_W-1:0] high_value;
    logic [CNT_W-1:0]           column_count;
    logic                       valid_res;
  } mcd_out_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] low_value;
    logic signed [SAMPLE_W-1:0] high_value;
  } mcd_entry_t;

  typedef struct packed {
    logic             done;
    logic [Q_W-1:0]   quotient;
    logic [SPS_W-1:0] remainder;
  } mcd_div_res_t;

endpackage

`default_nettype wire

@@ design/mcd_column_ram.sv @@
// ----------------------------------------------------------------------------
// mcd_column_ram: column min/max store
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_column_ram #(
  parameter int DEPTH = mcd_pkg::MAX_COLUMNS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  mcd_pkg::mcd_entry_t wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output mcd_pkg::mcd_entry_t rdata
);
  import mcd_pkg::*;

  mcd_entry_t mem [DEPTH];
  mcd_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/mcd_divider.sv @@
// ----------------------------------------------------------------------------
// mcd_divider: restoring divider, one quotient bit per cycle
// rebuilds the column quotient and remainder of index*columns/samples
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mcd_pkg::Q_W-1:0]    dividend,
  input  logic [mcd_pkg::SPS_W-1:0]  divisor,
  output mcd_pkg::mcd_div_res_t      res
);
  import mcd_pkg::*;

  localparam int STEP_W = $clog2(Q_W + 1);

  logic [Q_W-1:0]    quo_r, quo_nxt;
  logic [SPS_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [SPS_W:0]    trial;
  logic [SPS_W:0]    diff;

  // partial remainder stays below the divisor, so the trial fits one extra bit
  assign trial = {rem_r, quo_r[Q_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      step_nxt = STEP_W'(Q_W);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[SPS_W-1:0];
        quo_nxt = {quo_r[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[SPS_W-1:0];
        quo_nxt = {quo_r[Q_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

`default_nettype wire

@@ design/minmax_column_decimator_unit.sv @@
// ----------------------------------------------------------------------------
// minmax_column_decimator_unit: min/max envelope decimator for display columns
// append: result strobe registered after the response state, no new request
//   while busy; the column quotient is tracked incrementally, but after a
//   write of columns or samples per screen, or a step of more than one column,
//   the next append rebuilds it: multiply, bit-serial divide, column lookup
// shift: one entry copied per cycle through the column memory
// read and other codes go straight to the response; the receiver cannot stall results
// reset clears count, index and state at once; payload and memory are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module minmax_column_decimator_unit #(
  parameter int MAX_COLUMNS = mcd_pkg::MAX_COLUMNS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         start,
  input  mcd_pkg::mcd_in_t             in_req,
  output logic                         busy,
  // result channel
  output logic                         out_valid,
  output mcd_pkg::mcd_out_t            out_res,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mcd_pkg::CFG_AW-1:0]   paddr,
  input  logic [mcd_pkg::CFG_DW-1:0]   pwdata,
  output logic [mcd_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import mcd_pkg::*;

  // address width of the memory, count width, common compare width
  localparam int AW   = $clog2(MAX_COLUMNS);
  localparam int CW   = $clog2(MAX_COLUMNS + 1);
  localparam int CMPW = (CW > CV_W) ? CW : CV_W;

  // configuration registers
  logic [CV_W-1:0]  cv_r;
  logic [SPS_W-1:0] sps_r;
  logic [SS_W-1:0]  ss_r;

  // control and tracking state
  mcd_state_t       state_r, state_nxt;
  mcd_in_t          req_r, req_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [SPS_W-1:0] rem_r, rem_nxt;
  logic             dirty_r, dirty_nxt;
  logic [CW-1:0]    total_r, total_nxt;
  mcd_act_t         act_r, act_nxt;
  mcd_status_t      status_r, status_nxt;
  logic [AW-1:0]    col_r, col_nxt;
  logic [Q_W-1:0]   prod_r;
  logic [CW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]    left_r, left_nxt;
  logic             wpend_r, wpend_nxt;
  logic             out_valid_r;
  mcd_out_t         out_res_r, out_res_nxt;

  logic accept;
  logic cfg_wr;

  // memory port
  logic       ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  mcd_entry_t ram_wdata, ram_rdata;

  // divider
  logic         div_start;
  mcd_div_res_t div_res;

  // append decision
  mcd_in_t        din;
  logic [Q_W-1:0] begin_q;
  logic [Q_W-1:0] cdiff;
  logic [Q_W-1:0] total_q;
  logic           q_lt_begin;
  logic           table_full;
  mcd_act_t       dec_act;
  mcd_status_t    dec_status;
  logic [AW-1:0]  dec_col;
  logic           need_rebuild;

  // shift decision
  logic [SS_W-1:0] drop;
  logic [CMPW-1:0] drop_w, total_w, keep_w;
  logic            shift_noop, shift_all;
  logic            read_hit;

  // incremental column tracking
  logic [IDX_W-1:0] idx_inc;
  logic [SPS_W:0]   step_sum;
  logic [SPS_W:0]   step_sub;
  logic [SPS_W:0]   sps_ext;
  logic [SPS_W:0]   sps_dbl;

  // update of the addressed entry
  mcd_entry_t new_entry;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // ---------------------------------------------------------------------------
  // configuration registers; a change of the mapping forces a quotient rebuild
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r  <= CV_RST;
      sps_r <= SPS_RST;
      ss_r  <= SS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_COLS:  cv_r  <= pwdata[CV_W-1:0];
        REG_SPS:   sps_r <= pwdata[SPS_W-1:0];
        REG_SHIFT: ss_r  <= pwdata[SS_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_COLS:  prdata = CFG_DW'(cv_r);
      REG_SPS:   prdata = CFG_DW'(sps_r);
      REG_SHIFT: prdata = CFG_DW'(ss_r);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // append decision: column = quotient - begin, checked against the count
  // in idle it works on the incoming request, after a rebuild on the held one
  // ---------------------------------------------------------------------------
  assign din        = (state_r == ST_IDLE) ? in_req : req_r;
  assign begin_q    = Q_W'(din.begin_column);
  assign total_q    = Q_W'(total_r);
  assign q_lt_begin = (q_r < begin_q);
  assign cdiff      = q_r - begin_q;
  assign table_full = (total_r >= CW'(MAX_COLUMNS));
  assign dec_col    = cdiff[AW-1:0];
  assign need_rebuild = dirty_r && (sps_r != '0);

  always_comb begin
    dec_act    = ACT_NONE;
    dec_status = STAT_RANGE;
    if (sps_r == '0 || q_lt_begin) begin
      dec_act    = ACT_NONE;
      dec_status = STAT_RANGE;
    end else if (cdiff == total_q) begin
      if (table_full) begin
        dec_act    = ACT_NONE;
        dec_status = STAT_FULL;
      end else begin
        dec_act    = ACT_APPEND;
        dec_status = STAT_OK;
      end
    end else if (cdiff < total_q) begin
      dec_act    = ACT_UPDATE;
      dec_status = STAT_OK;
    end
  end

  // shift drops shift_step-1 leading columns, a zero step counts as one
  assign drop       = (ss_r == '0) ? '0 : ss_r - 1'b1;
  assign drop_w     = CMPW'(drop);
  assign total_w    = CMPW'(total_r);
  assign keep_w     = total_w - drop_w;
  assign shift_noop = (total_r == '0) || (drop == '0);
  assign shift_all  = (drop_w >= total_w);
  assign read_hit   = (CMPW'(in_req.read_column) < total_w);

  // next column position: remainder grows by the column count per sample,
  // one subtract covers it; a larger carry falls back to a full rebuild
  assign idx_inc  = idx_r + 1'b1;
  assign sps_ext  = {1'b0, sps_r};
  assign sps_dbl  = {sps_r, 1'b0};
  assign step_sum = {1'b0, rem_r} + (SPS_W + 1)'(cv_r);
  assign step_sub = step_sum - sps_ext;

  // min/max merge of the held sample into the entry read back
  always_comb begin
    new_entry = ram_rdata;
    if (act_r == ACT_APPEND) begin
      new_entry.low_value  = req_r.sample;
      new_entry.high_value = req_r.sample;
    end else begin
      if (req_r.sample < ram_rdata.low_value) begin
        new_entry.low_value = req_r.sample;
      end
      if (req_r.sample > ram_rdata.high_value) begin
        new_entry.high_value = req_r.sample;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_req.op)
            OP_APPEND: state_nxt = need_rebuild ? ST_MUL : ST_RESP;
            OP_SHIFT:  state_nxt = (!shift_noop && !shift_all) ? ST_SHIFT : ST_RESP;
            default:   state_nxt = ST_RESP;
          endcase
        end
      end
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV:   state_nxt = div_res.done ? ST_COL : ST_DIV;
      ST_COL:   state_nxt = ST_RESP;
      ST_RESP:  state_nxt = ST_IDLE;
      ST_SHIFT: state_nxt = (left_r == '0) ? ST_RESP : ST_SHIFT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: memory and divider controls, result word
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_re      = 1'b0;
    ram_raddr   = dec_col;
    ram_we      = 1'b0;
    ram_waddr   = col_r;
    ram_wdata   = new_entry;
    div_start   = 1'b0;
    out_res_nxt = out_res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_req.op == OP_APPEND && !need_rebuild) begin
          ram_re    = 1'b1;
          ram_raddr = dec_col;
        end else if (start && in_req.op == OP_READ) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(in_req.read_column);
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
      end
      ST_COL: begin
        ram_re    = 1'b1;
        ram_raddr = dec_col;
      end
      ST_SHIFT: begin
        // read runs one entry ahead of the write, always at a higher address
        if (left_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = rd_ptr_r[AW-1:0];
        end
        if (wpend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wr_ptr_r;
          ram_wdata = ram_rdata;
        end
      end
      ST_RESP: begin
        out_res_nxt.status       = status_r;
        out_res_nxt.column       = '0;
        out_res_nxt.low_value    = '0;
        out_res_nxt.high_value   = '0;
        out_res_nxt.column_count = CNT_W'(total_nxt);
        out_res_nxt.valid_res    = 1'b0;
        case (act_r)
          ACT_APPEND, ACT_UPDATE: begin
            ram_we                   = 1'b1;
            ram_waddr                = col_r;
            ram_wdata                = new_entry;
            out_res_nxt.column       = COL_W'(col_r);
            out_res_nxt.low_value    = new_entry.low_value;
            out_res_nxt.high_value   = new_entry.high_value;
            out_res_nxt.valid_res    = 1'b1;
          end
          ACT_READ: begin
            out_res_nxt.column       = COL_W'(col_r);
            out_res_nxt.low_value    = ram_rdata.low_value;
            out_res_nxt.high_value   = ram_rdata.high_value;
            out_res_nxt.valid_res    = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath next values
  // ---------------------------------------------------------------------------
  always_comb begin
    req_nxt    = req_r;
    idx_nxt    = idx_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    dirty_nxt  = dirty_r;
    total_nxt  = total_r;
    act_nxt    = act_r;
    status_nxt = status_r;
    col_nxt    = col_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    left_nxt   = left_r;
    wpend_nxt  = wpend_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt    = in_req;
          act_nxt    = ACT_NONE;
          status_nxt = STAT_OK;
          case (in_req.op)
            OP_APPEND: begin
              act_nxt    = dec_act;
              status_nxt = dec_status;
              col_nxt    = dec_col;
            end
            OP_SHIFT: begin
              if (!shift_noop) begin
                if (shift_all) begin
                  total_nxt = '0;
                end else begin
                  total_nxt  = CW'(keep_w);
                  left_nxt   = CW'(keep_w);
                  rd_ptr_nxt = CW'(drop_w);
                  wr_ptr_nxt = '0;
                  wpend_nxt  = 1'b0;
                end
              end
            end
            OP_READ: begin
              if (read_hit) begin
                act_nxt = ACT_READ;
                col_nxt = AW'(in_req.read_column);
              end else begin
                status_nxt = STAT_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          q_nxt     = div_res.quotient;
          rem_nxt   = div_res.remainder;
          dirty_nxt = 1'b0;
        end
      end
      ST_COL: begin
        act_nxt    = dec_act;
        status_nxt = dec_status;
        col_nxt    = dec_col;
      end
      ST_SHIFT: begin
        if (left_r != '0) begin
          rd_ptr_nxt = rd_ptr_r + 1'b1;
          left_nxt   = left_r - 1'b1;
          wpend_nxt  = 1'b1;
        end else begin
          wpend_nxt  = 1'b0;
        end
        if (wpend_r) begin
          wr_ptr_nxt = wr_ptr_r + 1'b1;
        end
      end
      ST_RESP: begin
        if (act_r == ACT_APPEND) begin
          total_nxt = total_r + 1'b1;
        end
        // every append request moves the sample index, dropped or not
        if (req_r.op == OP_APPEND) begin
          idx_nxt = idx_inc;
          if (idx_inc == '0) begin
            q_nxt     = '0;
            rem_nxt   = '0;
            dirty_nxt = 1'b0;
          end else if (dirty_r || sps_r == '0) begin
            dirty_nxt = 1'b1;
          end else if (step_sum < sps_ext) begin
            rem_nxt = step_sum[SPS_W-1:0];
          end else if (step_sum < sps_dbl) begin
            rem_nxt = step_sub[SPS_W-1:0];
            q_nxt   = q_r + 1'b1;
          end else begin
            dirty_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // mapping changed: quotient must be rebuilt from the index
    if (cfg_wr && (paddr[3:2] == REG_COLS || paddr[3:2] == REG_SPS)) begin
      dirty_nxt = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      q_r         <= '0;
      rem_r       <= '0;
      dirty_r     <= 1'b0;
      total_r     <= '0;
      act_r       <= ACT_NONE;
      status_r    <= STAT_OK;
      left_r      <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      q_r         <= q_nxt;
      rem_r       <= rem_nxt;
      dirty_r     <= dirty_nxt;
      total_r     <= total_nxt;
      act_r       <= act_nxt;
      status_r    <= status_nxt;
      left_r      <= left_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= (state_r == ST_RESP);
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    col_r     <= col_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    wr_ptr_r  <= wr_ptr_nxt;
    out_res_r <= out_res_nxt;
    // product for a rebuild, taken while idle; 32x11 bit multiply
    if (state_r == ST_IDLE) begin
      prod_r <= idx_r * cv_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // ---------------------------------------------------------------------------
  // column memory and divider
  // ---------------------------------------------------------------------------
  mcd_column_ram #(
    .DEPTH (MAX_COLUMNS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mcd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (sps_r),
    .res      (div_res)
  );

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a result strobe only follows the response cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_RESP))
    else $error("result strobe without a response cycle");

  // the fill count never passes the table depth
  assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CW'(MAX_COLUMNS))
    else $error("column count beyond table depth");

  // a clean tracked remainder stays below the divisor
  assert property (@(posedge clk) disable iff (!rst_n)
    (!dirty_r && sps_r != '0) |-> (rem_r < sps_r))
    else $error("tracked remainder out of range");

  // during the left shift a pending write trails the read pointer
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && wpend_r) |-> (CW'(wr_ptr_r) < rd_ptr_r))
    else $error("shift write overtakes read");

endmodule

`default_nettype wire

@@ sim/minmax_column_decimator_unit_test.sv @@
// ----------------------------------------------------------------------------
// minmax_column_decimator_unit_test: self-checking bench of the envelope decimator
// drives append, shift, read and unused requests through the start/busy channel,
// predicts every result from a local copy of the column table and the settings,
// and compares each strobed result field by field with the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module minmax_column_decimator_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  import mcd_pkg::*;

  localparam int unsigned TB_COLUMNS = MAX_COLUMNS_DEF;
  // the op field has room for a fourth code that the block must treat as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // limit for the whole run, well beyond the worst case of full-table shifts,
  // quotient rebuilds and sender gaps
  localparam longint unsigned RUN_LIMIT_NS = 64'd60_000_000;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // request channel
  logic     start = 1'b0;
  mcd_in_t  in_req = '0;
  logic     busy;

  // result channel
  logic     out_valid;
  mcd_out_t out_res;

  // configuration port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  minmax_column_decimator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // local copy of the block's settings, mirrored at each register write
  logic [CV_W-1:0]  cols_cfg = CV_RST;
  logic [SPS_W-1:0] sps_cfg  = SPS_RST;
  logic [SS_W-1:0]  step_cfg = SS_RST;

  // local copy of the envelope state
  logic [IDX_W-1:0]           idx_mirror = '0;
  int unsigned                filled_cols = 0;
  logic signed [SAMPLE_W-1:0] col_low  [TB_COLUMNS];
  logic signed [SAMPLE_W-1:0] col_high [TB_COLUMNS];

  // predicted results in request order
  mcd_out_t pending_envelopes[$];

  int unsigned mismatch_count = 0;
  int unsigned request_count = 0;
  int unsigned result_count = 0;
  bit          steady = 1'b0;   // no sender gaps while set

  // result seen at the rising edge, checked at the following falling edge
  bit       strobe_seen = 1'b0;
  mcd_out_t seen_res;
  mcd_out_t oldest_envelope;

  // column quotient the block would compute for the next append
  function automatic logic [63:0] quot_now();
    return ({32'd0, idx_mirror} * 64'(cols_cfg)) / 64'(sps_cfg);
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: applies one accepted request to the local table
  // ---------------------------------------------------------------------------
  task automatic predict_envelope(input mcd_in_t req, output mcd_out_t res);
    logic [63:0]   quot;
    logic [63:0]   col;
    bit            hit;
    int unsigned   drop;
    int unsigned   keep;
    int unsigned   rd;
    res = '0;
    hit = 1'b0;
    case (req.op)
      OP_APPEND: begin
        // quotient uses the index before it advances, dropped or not
        if (sps_cfg == '0) begin
          idx_mirror = idx_mirror + 1'b1;
          res.status = STAT_RANGE;
        end else begin
          quot = quot_now();
          idx_mirror = idx_mirror + 1'b1;
          if (quot < 64'(req.begin_column)) begin
            // column left of the visible window
            res.status = STAT_RANGE;
          end else begin
            col = quot - 64'(req.begin_column);
            if (col == 64'(filled_cols)) begin
              if (filled_cols >= TB_COLUMNS) begin
                res.status = STAT_FULL;
              end else begin
                // opens the next free column
                col_low[col]  = req.sample;
                col_high[col] = req.sample;
                filled_cols++;
                hit = 1'b1;
              end
            end else if (col < 64'(filled_cols)) begin
              // widens a filled column
              if (req.sample < col_low[col]) col_low[col] = req.sample;
              if (req.sample > col_high[col]) col_high[col] = req.sample;
              hit = 1'b1;
            end else begin
              res.status = STAT_RANGE;
            end
            if (hit) begin
              res.status     = STAT_OK;
              res.column     = col[COL_W-1:0];
              res.low_value  = col_low[col];
              res.high_value = col_high[col];
              res.valid_res  = 1'b1;
            end
          end
        end
      end
      OP_SHIFT: begin
        // a step of zero behaves as one, dropping nothing
        drop = (step_cfg == '0) ? 0 : int'(step_cfg) - 1;
        if (filled_cols > 0 && drop > 0) begin
          if (drop >= filled_cols) begin
            filled_cols = 0;
          end else begin
            keep = filled_cols - drop;
            for (int unsigned i = 0; i < keep; i++) begin
              col_low[i]  = col_low[i + drop];
              col_high[i] = col_high[i + drop];
            end
            filled_cols = keep;
          end
        end
        res.status = STAT_OK;
      end
      OP_READ: begin
        rd = int'(req.read_column);
        if (rd < filled_cols) begin
          res.status     = STAT_OK;
          res.column     = req.read_column;
          res.low_value  = col_low[rd];
          res.high_value = col_high[rd];
          res.valid_res  = 1'b1;
        end else begin
          res.status = STAT_RANGE;
        end
      end
      default: begin
        // unused code leaves the table alone
        res.status = STAT_OK;
      end
    endcase
    res.column_count = CNT_W'(filled_cols);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // every field but the op random, so ignored fields still toggle all their bits
  function automatic mcd_in_t noise_request();
    mcd_in_t req;
    req.op           = OP_READ;
    req.sample       = SAMPLE_W'($urandom);
    req.begin_column = BEGIN_W'($urandom);
    req.read_column  = COL_W'($urandom);
    return req;
  endfunction

  // begin column that makes the next append land on the target column
  function automatic logic [BEGIN_W-1:0] begin_for(input int unsigned target);
    logic [63:0] quot;
    if (sps_cfg == '0) return BEGIN_W'($urandom);
    quot = quot_now();
    if (quot >= 64'(target) && quot - 64'(target) <= 64'hFF_FFFF)
      return BEGIN_W'(quot - 64'(target));
    // target unreachable at this index, falls into the range error
    return BEGIN_W'($urandom);
  endfunction

  // mostly well-formed appends, with updates, errors, reads and shifts mixed in
  function automatic mcd_in_t make_request(input int unsigned new_pct);
    mcd_in_t     req;
    int unsigned pick;
    logic [63:0] quot;
    req = noise_request();
    if ($urandom_range(99) < new_pct) begin
      req.op = OP_APPEND;
      req.begin_column = begin_for(filled_cols);
      return req;
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      // widen an existing column
      req.op = OP_APPEND;
      req.begin_column = begin_for(filled_cols > 0 ? $urandom_range(filled_cols - 1) : 0);
    end else if (pick < 52) begin
      // skip past the next free column
      req.op = OP_APPEND;
      req.begin_column = begin_for(filled_cols + $urandom_range(1, 5));
    end else if (pick < 60) begin
      // column below zero
      req.op = OP_APPEND;
      quot = (sps_cfg == '0) ? 64'd0 : quot_now();
      req.begin_column = (quot + 64'd3 <= 64'hFF_FFFF) ?
                         BEGIN_W'(quot + 64'($urandom_range(1, 3))) : '1;
    end else if (pick < 64) begin
      // append with a fully random begin column
      req.op = OP_APPEND;
    end else if (pick < 84) begin
      req.op = OP_READ;
      if (filled_cols > 0 && $urandom_range(3) != 0)
        req.read_column = COL_W'($urandom_range(filled_cols - 1));
    end else if (pick < 96) begin
      req.op = OP_SHIFT;
    end else begin
      req.op = OP_UNUSED;
    end
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // channel tasks
  // ---------------------------------------------------------------------------

  // offers one request and waits for the edge that takes it
  task automatic issue_request(input mcd_in_t req);
    mcd_out_t want;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 18) begin
      // sender gap, landing on varying phases of the work
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy !== 1'b0);
    // accepted at this edge: predict now, before the next request is formed
    predict_envelope(req, want);
    pending_envelopes.push_back(want);
    request_count++;
  endtask

  // drops start and waits until every predicted result has come back
  task automatic settle_block();
    @(negedge clk);
    start <= 1'b0;
    while (pending_envelopes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // two-phase register write, only called while the block is idle
  task automatic write_register(input logic [1:0] reg_id, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_id, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (reg_id)
      REG_COLS:  cols_cfg = value[CV_W-1:0];
      REG_SPS:   sps_cfg  = value[SPS_W-1:0];
      REG_SHIFT: step_cfg = value[SS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(input int unsigned cols, input int unsigned sps,
                                input int unsigned step);
    settle_block();
    write_register(REG_COLS, CFG_DW'(cols));
    write_register(REG_SPS, CFG_DW'(sps));
    write_register(REG_SHIFT, CFG_DW'(step));
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %0s: got %0h want %0h (result %0d)", what, got, want, result_count);
    mismatch_count++;
  endtask

  // sample at the rising edge that ends the strobe cycle
  always @(posedge clk) begin
    strobe_seen = (rst_n === 1'b1) && (out_valid === 1'b1);
    seen_res    = out_res;
  end

  // compare at the falling edge, clear of the sender's push at the rising edge
  always @(negedge clk) begin
    if (strobe_seen) begin
      result_count++;
      if (pending_envelopes.size() == 0) begin
        flag_mismatch("unexpected result", 32'(seen_res), 32'd0);
      end else begin
        oldest_envelope = pending_envelopes.pop_front();
        if (seen_res.status !== oldest_envelope.status)
          flag_mismatch("status", 32'(seen_res.status), 32'(oldest_envelope.status));
        if (seen_res.column !== oldest_envelope.column)
          flag_mismatch("column", 32'(seen_res.column), 32'(oldest_envelope.column));
        if (seen_res.low_value !== oldest_envelope.low_value)
          flag_mismatch("low_value", 32'(seen_res.low_value), 32'(oldest_envelope.low_value));
        if (seen_res.high_value !== oldest_envelope.high_value)
          flag_mismatch("high_value", 32'(seen_res.high_value),
                        32'(oldest_envelope.high_value));
        if (seen_res.column_count !== oldest_envelope.column_count)
          flag_mismatch("column_count", 32'(seen_res.column_count),
                        32'(oldest_envelope.column_count));
        if (seen_res.valid_res !== oldest_envelope.valid_res)
          flag_mismatch("valid_res", 32'(seen_res.valid_res), 32'(oldest_envelope.valid_res));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: sample extremes, negative column, reads, unused code, zero
  // samples per screen
  task automatic check_reset_defaults();
    mcd_in_t req;
    // index 0 maps to column 0: opens it with the most negative sample
    req = noise_request();
    req.op = OP_APPEND;
    req.sample = 24'sh800000;
    req.begin_column = '0;
    issue_request(req);
    // still column 0: widened by the most positive sample
    req = noise_request();
    req.op = OP_APPEND;
    req.sample = 24'sh7FFFFF;
    req.begin_column = '0;
    issue_request(req);
    // largest begin column puts the sample below zero
    req = noise_request();
    req.op = OP_APPEND;
    req.begin_column = '1;
    issue_request(req);
    req = noise_request();
    req.op = OP_READ;
    req.read_column = '0;
    issue_request(req);
    // read beyond the count
    req = noise_request();
    req.op = OP_READ;
    req.read_column = '1;
    issue_request(req);
    req = noise_request();
    req.op = OP_UNUSED;
    issue_request(req);
    // step of one drops nothing
    req = noise_request();
    req.op = OP_SHIFT;
    issue_request(req);
    // zero samples per screen drops the sample, index still advances
    settle_block();
    write_register(REG_SPS, '0);
    req = noise_request();
    req.op = OP_APPEND;
    issue_request(req);
  endtask

  // register extremes, step of zero and shifts that empty the table
  task automatic check_config_extremes();
    mcd_in_t req;
    settle_block();
    write_register(REG_COLS, CFG_DW'(1024));
    write_register(REG_SPS, CFG_DW'(1));
    req = noise_request();
    req.op = OP_APPEND;
    req.begin_column = begin_for(filled_cols);
    issue_request(req);
    // two past the next free column
    req = noise_request();
    req.op = OP_APPEND;
    req.begin_column = begin_for(filled_cols + 2);
    issue_request(req);
    req = noise_request();
    req.op = OP_APPEND;
    req.sample = '0;
    req.begin_column = begin_for(0);
    issue_request(req);
    // narrowest plot, widest screen: quotient stays at zero
    settle_block();
    write_register(REG_COLS, CFG_DW'(1));
    write_register(REG_SPS, CFG_DW'(24'hFF_FFFF));
    req = noise_request();
    req.op = OP_APPEND;
    req.begin_column = '0;
    issue_request(req);
    // step of zero acts as one
    settle_block();
    write_register(REG_SHIFT, '0);
    req = noise_request();
    req.op = OP_SHIFT;
    issue_request(req);
    // a step of 1024 drops every column
    settle_block();
    write_register(REG_SHIFT, CFG_DW'(1024));
    req = noise_request();
    req.op = OP_SHIFT;
    issue_request(req);
    req = noise_request();
    req.op = OP_READ;
    req.read_column = '0;
    issue_request(req);
    // shift of an empty table
    req = noise_request();
    req.op = OP_SHIFT;
    issue_request(req);
  endtask

  // random traffic under several settings
  task automatic check_mixed_traffic();
    apply_settings(1024, 1024, 3);
    repeat (75) issue_request(make_request(40));
    apply_settings(1024, 1, 2);
    repeat (75) issue_request(make_request(40));
    apply_settings($urandom_range(1, 1024), $urandom_range(1, 5000), $urandom_range(1, 8));
    repeat (75) issue_request(make_request(40));
    apply_settings(3, 24'hFF_FFFF, 1024);
    repeat (75) issue_request(make_request(40));
  endtask

  // fills every column, presses against the full table, then shifts it away
  task automatic check_table_full();
    mcd_in_t     req;
    int unsigned sent;
    apply_settings(1024, 1024, 1);
    // one column per sample; back-to-back requests at first
    steady = 1'b1;
    sent = 0;
    while (filled_cols < TB_COLUMNS) begin
      issue_request(make_request(88));
      sent++;
      if (sent == 300) steady = 1'b0;
    end
    steady = 1'b0;
    // appends at the next column now report a full table
    repeat (30) issue_request(make_request(60));
    // drop all but the last column
    settle_block();
    write_register(REG_SHIFT, CFG_DW'(1024));
    req = noise_request();
    req.op = OP_SHIFT;
    issue_request(req);
    req = noise_request();
    req.op = OP_READ;
    req.read_column = '0;
    issue_request(req);
    repeat (20) issue_request(make_request(50));
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    // reset held from the start, released at a falling edge
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    check_reset_defaults();
    check_config_extremes();
    check_mixed_traffic();
    check_table_full();
    // drain, then give the block room for a late stray strobe
    settle_block();
    repeat (60) @(negedge clk);
    if (mismatch_count == 0 && pending_envelopes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop for a hung handshake
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
